/* hdl/pid_antiwindup_filtered_deriv_defines.svh */
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Shared property forms for the checker; each assumes clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef PID_ANTIWINDUP_FILTERED_DERIV_DEFINES_SVH
`define PID_ANTIWINDUP_FILTERED_DERIV_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PIDF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PIDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pidf_pkg.sv */
// ----------------------------------------------------------------------------
// PID controller package
// Widths, register codes and sequencer states shared by the PID modules.
// ----------------------------------------------------------------------------
package pidf_pkg;

  // Default sizes of the sample path and of the integral accumulator.
  localparam int SAMPLE_BITS_DEF = 8;
  localparam int SUM_BITS_DEF    = 32;

  // Fixed formats: Q8.8 gains, 32-bit Q.8 terms.
  localparam int GAIN_BITS      = 16;
  localparam int FRAC_BITS      = 8;
  localparam int TERM_BITS      = 32;
  localparam int DIVISOR_BITS   = 8;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;

  // Gain times a 32-bit term, brought back to Q.8.
  localparam int QUO_BITS = TERM_BITS + GAIN_BITS - FRAC_BITS;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEGRAL_GAIN  = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_FILTER_DIVISOR = 3'd3,
    REG_TARGET_LEVEL   = 3'd4,
    REG_LOOP_ENABLE    = 3'd5
  } cfg_reg_t;

  // Step sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_F,
    S_DIV,
    S_MUL_D,
    S_MUL_I,
    S_MUL_P,
    S_FINISH
  } state_t;

endpackage

/* hdl/pid_antiwindup_filtered_deriv.sv */
// ----------------------------------------------------------------------------
// PID controller with back-calculation anti-windup and filtered derivative
// One PID step per enabled sample: saturating integral, filtered derivative,
// clipped drive byte with a clipped flag.
// ----------------------------------------------------------------------------
// Each enabled sample yields one result item once its step is through; the
// block takes a new sample only after that step ends. The step is set by one
// shared shift-add multiplier that runs four products (one step per gain bit)
// and by a restoring divider that forms the derivative filter feedback term;
// the output register lets the next sample in while a result still waits.
// With loop_enable low a sample is taken but gives no result. Configuration
// is to be written only while the block is idle; the block does not enforce it.
module pid_antiwindup_filtered_deriv #(
  parameter int SAMPLE_BITS = pidf_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_BITS    = pidf_pkg::SUM_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_ready,
  input  logic [SAMPLE_BITS-1:0]               sample,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic [SAMPLE_BITS-1:0]               drive,
  output logic                                 clipped,
  input  logic                                 cfg_write,
  input  logic [pidf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [pidf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int GB         = pidf_pkg::GAIN_BITS;
  localparam int FB         = pidf_pkg::FRAC_BITS;
  localparam int TB         = pidf_pkg::TERM_BITS;
  localparam int DB         = pidf_pkg::DIVISOR_BITS;
  localparam int QB         = pidf_pkg::QUO_BITS;
  localparam int ERR_BITS   = SAMPLE_BITS + 1;
  localparam int DIFF_BITS  = SAMPLE_BITS + 2;
  localparam int ESC_BITS   = ERR_BITS + FB;
  localparam int MC_BITS    = (SUM_BITS > TB) ? SUM_BITS : TB;
  localparam int PROD_BITS  = MC_BITS + GB;
  localparam int EMOD_BITS  = TB + 2;
  localparam int SUMX_BITS  = ((SUM_BITS > EMOD_BITS) ? SUM_BITS : EMOD_BITS) + 1;
  localparam int DTERM_BITS = GB + DIFF_BITS;
  localparam int C1X_BITS   = QB + 2;
  localparam int ITERM_BITS = PROD_BITS - FB;
  localparam int BRX_BITS   = ITERM_BITS + 2;
  localparam int M_BITS     = TB + GB - FB;
  localparam int CLIPX_BITS = M_BITS + 1;
  localparam logic signed [M_BITS-1:0] DRIVE_HI =
    M_BITS'((2**SAMPLE_BITS - 1) * 2**FB);

  // Configuration registers.
  logic signed [GB-1:0]    prop_gain;
  logic signed [GB-1:0]    integral_gain;
  logic signed [GB-1:0]    deriv_gain;
  logic [DB-1:0]           filter_divisor;
  logic [SAMPLE_BITS-1:0]  target_level;
  logic                    loop_enable;

  // Controller state kept from step to step.
  logic signed [SUM_BITS-1:0] error_sum;
  logic signed [ERR_BITS-1:0] last_error;
  logic signed [TB-1:0]       last_deriv_term;
  logic signed [TB-1:0]       clip_difference;

  // Sequencer.
  pidf_pkg::state_t state;
  pidf_pkg::state_t state_next;
  logic             launch;

  // Per-step working registers.
  logic signed [ERR_BITS-1:0] err_reg;
  logic signed [TB-1:0]       deriv_term;
  logic signed [TB-1:0]       bracket;

  // Arithmetic units.
  logic                        mul_start;
  logic                        mul_done;
  logic signed [MC_BITS-1:0]   mul_mcand;
  logic signed [GB-1:0]        mul_gain;
  logic signed [PROD_BITS-1:0] mul_product;
  logic                        div_start;
  logic                        div_done;
  logic signed [QB-1:0]        div_quotient;
  logic signed [QB-1:0]        prod_q8;

  logic accept;
  logic finish_go;

  // Error and integral update.
  logic signed [ERR_BITS-1:0]  err_in;
  logic signed [ESC_BITS-1:0]  err_scaled_in;
  logic signed [EMOD_BITS-1:0] err_mod;
  logic signed [SUMX_BITS-1:0] sum_wide;
  logic                        sum_fits;
  logic signed [SUM_BITS-1:0]  sum_sat;

  // Derivative, bracket and drive.
  logic signed [DIFF_BITS-1:0]  err_diff;
  logic signed [DTERM_BITS-1:0] dterm;
  logic signed [C1X_BITS-1:0]   c1_wide;
  logic                         c1_fits;
  logic signed [TB-1:0]         c1_sat;
  logic signed [ITERM_BITS-1:0] iterm;
  logic signed [ESC_BITS-1:0]   err_scaled;
  logic signed [BRX_BITS-1:0]   br_wide;
  logic                         br_fits;
  logic signed [TB-1:0]         br_sat;
  logic signed [M_BITS-1:0]     m_sat;
  logic                         m_out;
  logic signed [CLIPX_BITS-1:0] clip_wide;
  logic                         clip_fits;
  logic signed [TB-1:0]         clip_sat;

  // Error and saturating integral with the last step's clipping difference.
  assign err_in        = $signed({1'b0, target_level}) - $signed({1'b0, sample});
  assign err_scaled_in = $signed({err_in, {FB{1'b0}}});
  assign err_mod       = EMOD_BITS'(err_scaled_in) + EMOD_BITS'(clip_difference);
  assign sum_wide      = SUMX_BITS'(error_sum) + SUMX_BITS'(err_mod);
  assign sum_fits      = (&sum_wide[SUMX_BITS-1:SUM_BITS-1]) ||
                         !(|sum_wide[SUMX_BITS-1:SUM_BITS-1]);
  assign sum_sat       = sum_fits ? sum_wide[SUM_BITS-1:0] :
                         (sum_wide[SUMX_BITS-1] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                                : {1'b0, {(SUM_BITS-1){1'b1}}});

  // Filtered derivative: Kd*(e - e_prev) minus the divided feedback term.
  assign err_diff = DIFF_BITS'(err_reg) - DIFF_BITS'(last_error);
  assign dterm    = $signed(mul_product[DTERM_BITS-1:0]);
  assign c1_wide  = C1X_BITS'(dterm) - C1X_BITS'(div_quotient);
  assign c1_fits  = (&c1_wide[C1X_BITS-1:TB-1]) || !(|c1_wide[C1X_BITS-1:TB-1]);
  assign c1_sat   = c1_fits ? c1_wide[TB-1:0] :
                    (c1_wide[C1X_BITS-1] ? {1'b1, {(TB-1){1'b0}}}
                                         : {1'b0, {(TB-1){1'b1}}});

  // Bracket e + Ki*sum - c1, saturated to 32 bits.
  assign iterm      = $signed(mul_product[PROD_BITS-1:FB]);
  assign err_scaled = $signed({err_reg, {FB{1'b0}}});
  assign br_wide    = BRX_BITS'(err_scaled) + BRX_BITS'(iterm) - BRX_BITS'(deriv_term);
  assign br_fits    = (&br_wide[BRX_BITS-1:TB-1]) || !(|br_wide[BRX_BITS-1:TB-1]);
  assign br_sat     = br_fits ? br_wide[TB-1:0] :
                      (br_wide[BRX_BITS-1] ? {1'b1, {(TB-1){1'b0}}}
                                           : {1'b0, {(TB-1){1'b1}}});

  // Gain product rounded down to Q.8; feeds the divider and the raw drive.
  assign prod_q8 = $signed(mul_product[TB+GB-1:FB]);

  // Drive clipping and the back-calculation difference.
  assign m_out     = prod_q8[M_BITS-1] || (prod_q8 > DRIVE_HI);
  assign m_sat     = prod_q8[M_BITS-1] ? '0 : ((prod_q8 > DRIVE_HI) ? DRIVE_HI : prod_q8);
  assign clip_wide = CLIPX_BITS'(m_sat) - CLIPX_BITS'(prod_q8);
  assign clip_fits = (&clip_wide[CLIPX_BITS-1:TB-1]) || !(|clip_wide[CLIPX_BITS-1:TB-1]);
  assign clip_sat  = clip_fits ? clip_wide[TB-1:0] :
                     (clip_wide[CLIPX_BITS-1] ? {1'b1, {(TB-1){1'b0}}}
                                              : {1'b0, {(TB-1){1'b1}}});

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      pidf_pkg::S_IDLE: begin
        if (sample_valid && loop_enable) begin
          state_next = pidf_pkg::S_MUL_F;
        end
      end
      pidf_pkg::S_MUL_F: begin
        if (mul_done) begin
          state_next = pidf_pkg::S_DIV;
        end
      end
      pidf_pkg::S_DIV: begin
        if (div_done) begin
          state_next = pidf_pkg::S_MUL_D;
        end
      end
      pidf_pkg::S_MUL_D: begin
        if (mul_done) begin
          state_next = pidf_pkg::S_MUL_I;
        end
      end
      pidf_pkg::S_MUL_I: begin
        if (mul_done) begin
          state_next = pidf_pkg::S_MUL_P;
        end
      end
      pidf_pkg::S_MUL_P: begin
        if (mul_done) begin
          state_next = pidf_pkg::S_FINISH;
        end
      end
      pidf_pkg::S_FINISH: begin
        if (!result_valid || result_ready) begin
          state_next = pidf_pkg::S_IDLE;
        end
      end
      default: state_next = pidf_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: unit starts and operand selection.
  always_comb begin
    sample_ready = 1'b0;
    mul_start    = 1'b0;
    div_start    = 1'b0;
    finish_go    = 1'b0;
    mul_mcand    = '0;
    mul_gain     = '0;
    unique case (state)
      pidf_pkg::S_IDLE: begin
        sample_ready = 1'b1;
      end
      pidf_pkg::S_MUL_F: begin
        mul_start = launch;
        mul_mcand = MC_BITS'(last_deriv_term);
        mul_gain  = deriv_gain;
      end
      pidf_pkg::S_DIV: begin
        div_start = launch;
      end
      pidf_pkg::S_MUL_D: begin
        mul_start = launch;
        mul_mcand = MC_BITS'(err_diff);
        mul_gain  = deriv_gain;
      end
      pidf_pkg::S_MUL_I: begin
        mul_start = launch;
        mul_mcand = MC_BITS'(error_sum);
        mul_gain  = integral_gain;
      end
      pidf_pkg::S_MUL_P: begin
        mul_start = launch;
        mul_mcand = MC_BITS'(bracket);
        mul_gain  = prop_gain;
      end
      pidf_pkg::S_FINISH: begin
        finish_go = !result_valid || result_ready;
      end
      default: begin
        sample_ready = 1'b0;
      end
    endcase
  end

  assign accept = sample_valid && sample_ready;

  // Control, configuration and controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= pidf_pkg::S_IDLE;
      launch          <= 1'b0;
      result_valid    <= 1'b0;
      prop_gain       <= '0;
      integral_gain   <= '0;
      deriv_gain      <= '0;
      filter_divisor  <= DB'(1);
      target_level    <= '0;
      loop_enable     <= 1'b0;
      error_sum       <= '0;
      last_error      <= '0;
      last_deriv_term <= '0;
      clip_difference <= '0;
    end else begin
      state        <= state_next;
      launch       <= (state_next != state);
      result_valid <= finish_go || (result_valid && !result_ready);

      if (cfg_write) begin
        unique case (cfg_index)
          pidf_pkg::REG_PROP_GAIN:      prop_gain      <= $signed(cfg_data[GB-1:0]);
          pidf_pkg::REG_INTEGRAL_GAIN:  integral_gain  <= $signed(cfg_data[GB-1:0]);
          pidf_pkg::REG_DERIV_GAIN:     deriv_gain     <= $signed(cfg_data[GB-1:0]);
          pidf_pkg::REG_FILTER_DIVISOR: filter_divisor <= cfg_data[DB-1:0];
          pidf_pkg::REG_TARGET_LEVEL:   target_level   <= cfg_data[SAMPLE_BITS-1:0];
          pidf_pkg::REG_LOOP_ENABLE:    loop_enable    <= cfg_data[0];
          default: begin
          end
        endcase
      end

      // The integral is committed as soon as an enabled sample is taken.
      if (accept && loop_enable) begin
        error_sum <= sum_sat;
      end

      if (finish_go) begin
        clip_difference <= clip_sat;
        last_error      <= err_reg;
        last_deriv_term <= deriv_term;
      end
    end
  end

  // Working and output data registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      err_reg <= err_in;
    end
    if (state == pidf_pkg::S_MUL_D && mul_done) begin
      deriv_term <= c1_sat;
    end
    if (state == pidf_pkg::S_MUL_I && mul_done) begin
      bracket <= br_sat;
    end
    if (finish_go) begin
      drive   <= m_sat[SAMPLE_BITS+FB-1:FB];
      clipped <= m_out;
    end
  end

  // Shared gain multiplier.
  pidf_mul #(
    .A_BITS (MC_BITS)
  ) u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (mul_mcand),
    .gain         (mul_gain),
    .done         (mul_done),
    .product      (mul_product)
  );

  // Derivative filter divider: floor(Kd*c1_prev / 256) / N.
  pidf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_q8),
    .divisor  (filter_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

/* hdl/pidf_mul.sv */
// ----------------------------------------------------------------------------
// PID serial multiplier
// Signed shift-add multiplier that retires one gain bit per cycle.
// ----------------------------------------------------------------------------
module pidf_mul #(
  parameter int A_BITS = pidf_pkg::TERM_BITS
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        start,
  input  logic signed [A_BITS-1:0]                    multiplicand,
  input  logic signed [pidf_pkg::GAIN_BITS-1:0]       gain,
  output logic                                        done,
  output logic signed [A_BITS+pidf_pkg::GAIN_BITS-1:0] product
);

  localparam int GB       = pidf_pkg::GAIN_BITS;
  localparam int CNT_BITS = $clog2(GB);

  logic                     busy;
  logic [CNT_BITS-1:0]      count;
  logic signed [A_BITS-1:0] mcand;
  logic signed [A_BITS:0]   acc_hi;
  logic [GB-1:0]            acc_lo;

  logic                     last_bit;
  logic signed [A_BITS+1:0] addend;
  logic signed [A_BITS+1:0] step_sum;

  // The gain's top bit has negative weight, so the last step subtracts.
  assign last_bit = (count == CNT_BITS'(GB - 1));

  always_comb begin
    if (!acc_lo[0]) begin
      addend = '0;
    end else if (last_bit) begin
      addend = -((A_BITS + 2)'(mcand));
    end else begin
      addend = (A_BITS + 2)'(mcand);
    end
    step_sum = (A_BITS + 2)'(acc_hi) + addend;
  end

  // Control: a run of GB steps after each start.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && last_bit;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        if (last_bit) begin
          busy <= 1'b0;
        end
        count <= count + 1'b1;
      end
    end
  end

  // Datapath: the low half holds unused gain bits and the finished product bits.
  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= multiplicand;
      acc_hi <= '0;
      acc_lo <= gain;
    end else if (busy) begin
      acc_hi <= step_sum[A_BITS+1:1];
      acc_lo <= {step_sum[0], acc_lo[GB-1:1]};
    end
  end

  assign product = $signed({acc_hi[A_BITS-1:0], acc_lo});

endmodule

/* hdl/pidf_div.sv */
// ----------------------------------------------------------------------------
// PID serial floor divider
// Restoring divider, one quotient bit per cycle, rounding toward minus infinity.
// ----------------------------------------------------------------------------
module pidf_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [pidf_pkg::QUO_BITS-1:0]  dividend,
  input  logic [pidf_pkg::DIVISOR_BITS-1:0]     divisor,
  output logic                                  done,
  output logic signed [pidf_pkg::QUO_BITS-1:0]  quotient
);

  localparam int QB       = pidf_pkg::QUO_BITS;
  localparam int DB       = pidf_pkg::DIVISOR_BITS;
  localparam int CNT_BITS = $clog2(QB);

  logic                busy;
  logic [CNT_BITS-1:0] count;
  logic [QB-1:0]       work;
  logic [DB-1:0]       rem;
  logic [DB-1:0]       dvsr;
  logic                neg;

  logic                last_bit;
  logic [DB:0]         trial;
  logic [DB:0]         diff;
  logic                fits;

  assign last_bit = (count == CNT_BITS'(QB - 1));

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem, work[QB-1]};
    diff  = trial - {1'b0, dvsr};
    fits  = (trial >= {1'b0, dvsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && last_bit;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        if (last_bit) begin
          busy <= 1'b0;
        end
        count <= count + 1'b1;
      end
    end
  end

  // A negative dividend is complemented; floor(a/n) equals ~floor(~a/n) then.
  // A zero divisor behaves as one.
  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[QB-1];
      work <= dividend[QB-1] ? ~dividend : dividend;
      rem  <= '0;
      dvsr <= (divisor == '0) ? DB'(1) : divisor;
    end else if (busy) begin
      rem  <= fits ? diff[DB-1:0] : trial[DB-1:0];
      work <= {work[QB-2:0], fits};
    end
  end

  assign quotient = $signed(neg ? ~work : work);

endmodule

/* hdl/pidf_checker.sv */
// ----------------------------------------------------------------------------
// PID controller port checker
// Watches the top-level ports for result and sequencing slips.
// ----------------------------------------------------------------------------
`include "pid_antiwindup_filtered_deriv_defines.svh"

module pidf_checker #(
  parameter int SAMPLE_BITS = pidf_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   sample_valid,
  input logic                   sample_ready,
  input logic                   result_valid,
  input logic                   result_ready,
  input logic [SAMPLE_BITS-1:0] drive,
  input logic                   clipped
);

  // A waiting result item holds still until it is taken.
  `PIDF_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(drive) && $stable(clipped), "result item changed before it was taken")

  // A clipped drive sits on one of the two rails.
  `PIDF_ASSERT_SAME(a_clip_rail, result_valid && clipped, (drive == '0) || (&drive), "clipped drive is not at a rail")

  // Results come only from the finish state, so none rises right after a sample.
  `PIDF_ASSERT_NEXT(a_no_instant_result, sample_valid && sample_ready, !$rose(result_valid), "result item appeared one cycle after a sample")

  // The block comes out of reset ready for a sample.
  `PIDF_ASSERT_SAME(a_ready_after_reset, $past(rst), sample_ready, "not ready for a sample after reset")

endmodule

bind pid_antiwindup_filtered_deriv pidf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (.*);

/* verif/tb_pid_antiwindup_filtered_deriv.sv */
// ----------------------------------------------------------------------------
// PID controller with anti-windup testbench
// Drives converter samples and register writes into the PID step block and
// checks every drive item against a cycle-free fixed-point model or the plan.
// ----------------------------------------------------------------------------
module tb_pid_antiwindup_filtered_deriv;
  timeunit 1ns;
  timeprecision 1ps;

  import pidf_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int ITEM_GOAL    = 2000;
  localparam int DRAIN_CYCLES = 130;
  localparam int HOLD_CYCLES  = 1000;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int REPORT_CAP   = 50;

  // Register indexes past the end of the map; writes to them are ignored.
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_B = 3'd7;

  // Fixed-point bounds of the step arithmetic.
  localparam longint Q_ONE     = longint'(1) <<< FRAC_BITS;
  localparam longint TERM_HI   = (longint'(1) <<< (TERM_BITS - 1)) - 1;
  localparam longint TERM_LO   = -(longint'(1) <<< (TERM_BITS - 1));
  localparam longint SUM_HI    = (longint'(1) <<< (SUM_BITS_DEF - 1)) - 1;
  localparam longint SUM_LO    = -(longint'(1) <<< (SUM_BITS_DEF - 1));
  localparam longint DRIVE_TOP = ((longint'(1) <<< SAMPLE_BITS_DEF) - 1) * Q_ONE;

  typedef enum logic [1:0] {ROW_REG, ROW_MODEL, ROW_FIXED} row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [CFG_INDEX_BITS-1:0]   idx;
    logic [CFG_DATA_BITS-1:0]    data;
    logic [SAMPLE_BITS_DEF-1:0]  meas;
    logic [SAMPLE_BITS_DEF-1:0]  drv;
    logic                        clp;
  } plan_row_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [SAMPLE_BITS_DEF-1:0]  drv;
    logic                        clp;
  } sample_note_t;

  typedef struct packed {
    logic [SAMPLE_BITS_DEF-1:0]  drv;
    logic                        clp;
  } drive_word_t;

  // Directed plan. Register rows write the block while it is idle; fixed rows
  // carry a drive that is obvious from the gains; model rows use the predictor.
  // The index column of a sample row is unused.
  localparam int PLAN_ROWS = 43;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // Loop still disabled after reset: no drive item.
    '{ROW_MODEL, REG_PROP_GAIN,      16'h0000, 8'hFF, 8'h00, 1'b0},
    '{ROW_MODEL, REG_PROP_GAIN,      16'h0000, 8'h00, 8'h00, 1'b0},
    // Enabled with all gains zero: drive stays at zero.
    '{ROW_REG,   REG_LOOP_ENABLE,    16'h0001, 8'h00, 8'h00, 1'b0},
    '{ROW_FIXED, REG_PROP_GAIN,      16'h0000, 8'h00, 8'h00, 1'b0},
    '{ROW_FIXED, REG_PROP_GAIN,      16'h0000, 8'hFF, 8'h00, 1'b0},
    // Unity proportional gain: drive equals the error.
    '{ROW_REG,   REG_PROP_GAIN,      16'h0100, 8'h00, 8'h00, 1'b0},
    '{ROW_REG,   REG_TARGET_LEVEL,   16'h00FF, 8'h00, 8'h00, 1'b0},
    '{ROW_FIXED, REG_PROP_GAIN,      16'h0000, 8'h00, 8'hFF, 1'b0},
    '{ROW_FIXED, REG_PROP_GAIN,      16'h0000, 8'hFF, 8'h00, 1'b0},
    '{ROW_FIXED, REG_PROP_GAIN,      16'h0000, 8'h55, 8'hAA, 1'b0},
    '{ROW_FIXED, REG_PROP_GAIN,      16'h0000, 8'hAA, 8'h55, 1'b0},
    // Negative error clips at zero.
    '{ROW_REG,   REG_TARGET_LEVEL,   16'h0000, 8'h00, 8'h00, 1'b0},
    '{ROW_FIXED, REG_PROP_GAIN,      16'h0000, 8'h01, 8'h00, 1'b1},
    '{ROW_FIXED, REG_PROP_GAIN,      16'h0000, 8'h00, 8'h00, 1'b0},
    // Largest and most negative proportional gain.
    '{ROW_REG,   REG_PROP_GAIN,      16'h7FFF, 8'h00, 8'h00, 1'b0},
    '{ROW_REG,   REG_TARGET_LEVEL,   16'h00FF, 8'h00, 8'h00, 1'b0},
    '{ROW_FIXED, REG_PROP_GAIN,      16'h0000, 8'h00, 8'hFF, 1'b1},
    '{ROW_REG,   REG_PROP_GAIN,      16'h8000, 8'h00, 8'h00, 1'b0},
    '{ROW_FIXED, REG_PROP_GAIN,      16'h0000, 8'h00, 8'h00, 1'b1},
    // Extreme gains with a zero filter divisor: derivative and integral saturate.
    '{ROW_REG,   REG_PROP_GAIN,      16'h7FFF, 8'h00, 8'h00, 1'b0},
    '{ROW_REG,   REG_INTEGRAL_GAIN,  16'h7FFF, 8'h00, 8'h00, 1'b0},
    '{ROW_REG,   REG_DERIV_GAIN,     16'h8000, 8'h00, 8'h00, 1'b0},
    '{ROW_REG,   REG_FILTER_DIVISOR, 16'h0000, 8'h00, 8'h00, 1'b0},
    '{ROW_MODEL, REG_PROP_GAIN,      16'h0000, 8'h00, 8'h00, 1'b0},
    '{ROW_MODEL, REG_PROP_GAIN,      16'h0000, 8'hFF, 8'h00, 1'b0},
    '{ROW_MODEL, REG_PROP_GAIN,      16'h0000, 8'h00, 8'h00, 1'b0},
    '{ROW_MODEL, REG_PROP_GAIN,      16'h0000, 8'hFF, 8'h00, 1'b0},
    '{ROW_MODEL, REG_PROP_GAIN,      16'h0000, 8'h00, 8'h00, 1'b0},
    // Opposite extremes, widest divisor, midscale setpoint.
    '{ROW_REG,   REG_FILTER_DIVISOR, 16'h00FF, 8'h00, 8'h00, 1'b0},
    '{ROW_REG,   REG_DERIV_GAIN,     16'h7FFF, 8'h00, 8'h00, 1'b0},
    '{ROW_REG,   REG_INTEGRAL_GAIN,  16'h8000, 8'h00, 8'h00, 1'b0},
    '{ROW_REG,   REG_TARGET_LEVEL,   16'h0080, 8'h00, 8'h00, 1'b0},
    '{ROW_MODEL, REG_PROP_GAIN,      16'h0000, 8'hFF, 8'h00, 1'b0},
    '{ROW_MODEL, REG_PROP_GAIN,      16'h0000, 8'h00, 8'h00, 1'b0},
    '{ROW_MODEL, REG_PROP_GAIN,      16'h0000, 8'h7F, 8'h00, 1'b0},
    '{ROW_MODEL, REG_PROP_GAIN,      16'h0000, 8'h80, 8'h00, 1'b0},
    // Writes past the register map must change nothing.
    '{ROW_REG,   REG_UNUSED_A,       16'hFFFF, 8'h00, 8'h00, 1'b0},
    '{ROW_REG,   REG_UNUSED_B,       16'h0000, 8'h00, 8'h00, 1'b0},
    '{ROW_MODEL, REG_PROP_GAIN,      16'h0000, 8'h80, 8'h00, 1'b0},
    // A disabled sample leaves the loop state alone.
    '{ROW_REG,   REG_LOOP_ENABLE,    16'h0000, 8'h00, 8'h00, 1'b0},
    '{ROW_MODEL, REG_PROP_GAIN,      16'h0000, 8'h33, 8'h00, 1'b0},
    '{ROW_REG,   REG_LOOP_ENABLE,    16'h0001, 8'h00, 8'h00, 1'b0},
    '{ROW_MODEL, REG_PROP_GAIN,      16'h0000, 8'h80, 8'h00, 1'b0}
  };

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        sample_valid;
  logic                        sample_ready;
  logic [SAMPLE_BITS_DEF-1:0]  sample;
  logic                        result_valid;
  logic                        result_ready;
  logic [SAMPLE_BITS_DEF-1:0]  drive;
  logic                        clipped;
  logic                        cfg_write;
  logic [CFG_INDEX_BITS-1:0]   cfg_index;
  logic [CFG_DATA_BITS-1:0]    cfg_data;

  // Predictor copy of the registers and of the loop state.
  logic signed [GAIN_BITS-1:0]  kp = '0;
  logic signed [GAIN_BITS-1:0]  ki = '0;
  logic signed [GAIN_BITS-1:0]  kd = '0;
  logic [DIVISOR_BITS-1:0]      fdiv = 8'd1;
  logic [SAMPLE_BITS_DEF-1:0]   setpoint = '0;
  logic                         loop_on = 1'b0;
  longint                       err_sum = 0;
  longint                       prev_err = 0;
  longint                       prev_deriv = 0;
  longint                       clip_diff = 0;

  sample_note_t  sample_notes [$];
  drive_word_t   drive_expect [$];
  int            fault_count = 0;
  int            live_items = 0;
  int            holds_asked = 0;
  bit            steady = 1'b0;

  pid_antiwindup_filtered_deriv i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .drive        (drive),
    .clipped      (clipped),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Quotient rounded toward minus infinity; the divisor is always positive.
  function automatic longint floor_quot(input longint num, input longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One PID step on an accepted sample. Returns 0 when the loop is off.
  function automatic bit next_drive(input logic [SAMPLE_BITS_DEF-1:0] meas,
                                    output logic [SAMPLE_BITS_DEF-1:0] drv,
                                    output logic clp);
    longint err, n, deriv, fb, c1, iterm, bracket, raw, held;
    drv = '0;
    clp = 1'b0;
    if (!loop_on) return 1'b0;

    // Error in counts; the integral also takes back the last clipping excess.
    err = longint'(setpoint) - longint'(meas);
    err_sum = clamp(err_sum + err * Q_ONE + clip_diff, SUM_LO, SUM_HI);

    // Filtered derivative; a zero divisor counts as one.
    n = (fdiv == '0) ? 1 : longint'(fdiv);
    deriv = longint'(kd) * (err - prev_err);
    fb = floor_quot(longint'(kd) * prev_deriv, n * Q_ONE);
    c1 = clamp(deriv - fb, TERM_LO, TERM_HI);

    iterm = floor_quot(longint'(ki) * err_sum, Q_ONE);
    bracket = clamp(err * Q_ONE + iterm - c1, TERM_LO, TERM_HI);
    raw = floor_quot(longint'(kp) * bracket, Q_ONE);

    held = clamp(raw, 0, DRIVE_TOP);
    clip_diff = clamp(held - raw, TERM_LO, TERM_HI);
    prev_err = err;
    prev_deriv = c1;

    drv = SAMPLE_BITS_DEF'(held >>> FRAC_BITS);
    clp = (raw < 0 || raw > DRIVE_TOP);
    return 1'b1;
  endfunction

  // Mostly modest gains so the drive often stays in range, some anywhere.
  function automatic logic [GAIN_BITS-1:0] pick_gain();
    int roll;
    int v;
    roll = $urandom_range(0, 9);
    if (roll < 6) begin
      v = int'($urandom_range(0, 1023)) - 512;
      return GAIN_BITS'(v);
    end
    if (roll < 8) return GAIN_BITS'($urandom);
    case ($urandom_range(0, 3))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'h0100;
    endcase
  endfunction

  // Samples mostly near the setpoint, the rest anywhere in range.
  function automatic logic [SAMPLE_BITS_DEF-1:0] next_meas();
    int v;
    if ($urandom_range(0, 9) < 3) return SAMPLE_BITS_DEF'($urandom_range(0, 255));
    v = int'(setpoint) + int'($urandom_range(0, 40)) - 20;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return SAMPLE_BITS_DEF'(v);
  endfunction

  // One register write; the task leaves the write enable high for a
  // following write, and the next sample offer lowers it.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_PROP_GAIN:      kp = data;
      REG_INTEGRAL_GAIN:  ki = data;
      REG_DERIV_GAIN:     kd = data;
      REG_FILTER_DIVISOR: fdiv = data[DIVISOR_BITS-1:0];
      REG_TARGET_LEVEL:   setpoint = data[SAMPLE_BITS_DEF-1:0];
      REG_LOOP_ENABLE:    loop_on = data[0];
      default: ;
    endcase
  endtask

  // Offer one sample item and return at the edge that accepts it.
  task automatic offer_sample(input logic [SAMPLE_BITS_DEF-1:0] meas,
                              input row_kind_t kind,
                              input logic [SAMPLE_BITS_DEF-1:0] drv,
                              input logic clp);
    sample_note_t note;
    note.kind = kind;
    note.drv  = drv;
    note.clp  = clp;
    sample_notes.push_back(note);
    cfg_write <= 1'b0;
    if (!steady && $urandom_range(0, 99) < 9) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 130)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= meas;
    do @(posedge clk); while (!sample_ready);
  endtask

  // Stop offering, wait for every pending drive item, then let a possible
  // silent step finish.
  task automatic settle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (drive_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // New gains, divisor, setpoint and enable for one random phase.
  task automatic random_setup(input bit force_on);
    logic [CFG_DATA_BITS-1:0] word;
    write_reg(REG_PROP_GAIN, pick_gain());
    if ($urandom_range(0, 3) != 0) write_reg(REG_INTEGRAL_GAIN, pick_gain());
    if ($urandom_range(0, 3) != 0) write_reg(REG_DERIV_GAIN, pick_gain());
    word = CFG_DATA_BITS'($urandom);
    case ($urandom_range(0, 4))
      0: word[7:0] = 8'h00;
      1: word[7:0] = 8'h01;
      2: word[7:0] = 8'hFF;
      default: ;
    endcase
    write_reg(REG_FILTER_DIVISOR, word);
    word = CFG_DATA_BITS'($urandom);
    if ($urandom_range(0, 5) == 0) word[7:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    write_reg(REG_TARGET_LEVEL, word);
    if ($urandom_range(0, 7) == 0)
      write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B,
                CFG_DATA_BITS'($urandom));
    word = CFG_DATA_BITS'($urandom);
    word[0] = force_on || ($urandom_range(0, 7) != 0);
    write_reg(REG_LOOP_ENABLE, word);
  endtask

  // Predict on each accepted sample, check each accepted drive item.
  always @(posedge clk) begin : scoreboard
    drive_word_t   want;
    drive_word_t   got;
    sample_note_t  note;
    logic [SAMPLE_BITS_DEF-1:0] d;
    logic c;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (drive_expect.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_CAP)
            $error("drive item with nothing expected: drive %0d, clipped %0d",
                   drive, clipped);
        end else begin
          want = drive_expect.pop_front();
          if (drive !== want.drv) begin
            fault_count++;
            if (fault_count <= REPORT_CAP)
              $error("drive: expected %0d, got %0d", want.drv, drive);
          end
          if (clipped !== want.clp) begin
            fault_count++;
            if (fault_count <= REPORT_CAP)
              $error("clipped: expected %0d, got %0d", want.clp, clipped);
          end
        end
      end
      if (sample_valid && sample_ready) begin
        note.kind = ROW_MODEL;
        note.drv  = '0;
        note.clp  = 1'b0;
        if (sample_notes.size() != 0) note = sample_notes.pop_front();
        if (next_drive(sample, d, c)) begin
          if (note.kind == ROW_FIXED) begin
            got.drv = note.drv;
            got.clp = note.clp;
          end else begin
            got.drv = d;
            got.clp = c;
          end
          drive_expect.push_back(got);
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is asked.
  initial begin : receiver
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served < holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= steady || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  // Hard stop if the run hangs.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Reset, directed plan, random phases, final verdict.
  initial begin : stimulus
    int  count;
    int  phase;
    bit  prev_reg;
    bit  pressure;
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    result_ready <= 1'b0;
    cfg_write    <= 1'b0;
    cfg_index    <= REG_PROP_GAIN;
    cfg_data     <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    prev_reg = 1'b0;
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (PLAN[r].kind == ROW_REG) begin
        if (!prev_reg) settle();
        write_reg(PLAN[r].idx, PLAN[r].data);
        prev_reg = 1'b1;
      end else begin
        offer_sample(PLAN[r].meas, PLAN[r].kind, PLAN[r].drv, PLAN[r].clp);
        prev_reg = 1'b0;
      end
    end

    // Random phases; each starts from an idle block with fresh settings.
    phase = 0;
    while (live_items < ITEM_GOAL) begin
      settle();
      steady   = (phase >= 4 && phase < 8);
      pressure = (phase == 2 || phase == 12);
      random_setup(pressure);
      if (pressure) holds_asked++;
      if (!loop_on) count = $urandom_range(4, 12);
      else if (pressure) count = 40;
      else count = $urandom_range(20, 80);
      repeat (count) begin
        offer_sample(next_meas(), ROW_MODEL, '0, 1'b0);
        if (loop_on) live_items++;
      end
      phase++;
    end
    steady = 1'b0;

    settle();
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
